// ===== src/bmf3_pkg.sv =====
package bmf3_pkg;

	localparam int VOXEL_BITS   = 16;
	localparam int MAX_DIM_DEF  = 256;
	localparam int MAX_MASK_DEF = 7;

	localparam int CFG_W     = 9;
	localparam int CFG_IDX_W = 2;
	localparam int MASK_W    = 3;

	localparam logic [CFG_IDX_W-1:0] REG_SIZE_X = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SIZE_Y = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SIZE_Z = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MASK   = 2'd3;

	localparam logic [CFG_W-1:0]  SIZE_RST = 9'd256;
	localparam logic [MASK_W-1:0] MASK_RST = 3'd3;

	localparam int FQ_DEPTH = 4;
	localparam int FQ_AW    = 2;

	typedef struct packed {
		logic signed [VOXEL_BITS-1:0] voxel_in;
		logic                         flush;
	} vox_t;

	typedef struct packed {
		logic signed [VOXEL_BITS-1:0] voxel_out;
		logic                         last;
	} res_t;

endpackage

// ===== src/box_mean_filter_3d.sv =====
// A border voxel is read from the voxel store (states RD0, RD1) once the transaction
// that completes it is taken; an interior voxel waits for its window reads and the divider.
// One transaction at a time in the back end; each window voxel is read through the
// single read port of the voxel store, then one quotient bit per cycle.
// Reset clears positions and control; configuration returns to defaults and the
// input is held off after reset or any register write.
module box_mean_filter_3d #(
	parameter int MAX_DIM  = bmf3_pkg::MAX_DIM_DEF,
	parameter int MAX_MASK = bmf3_pkg::MAX_MASK_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            vox_valid,
	output logic                            vox_stall,
	input  bmf3_pkg::vox_t                  vox,
	output logic                            res_valid,
	input  logic                            res_stall,
	output bmf3_pkg::res_t                  res,
	input  logic                            cfg_we,
	input  logic [bmf3_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bmf3_pkg::CFG_W-1:0]      cfg_wdata
);
	import bmf3_pkg::*;

	localparam int DW   = $clog2(MAX_DIM + 1);
	localparam int PLW  = $clog2(MAX_DIM * MAX_DIM + 1);
	localparam int POSW = $clog2(MAX_DIM * MAX_DIM * MAX_DIM + 1);
	localparam int RW   = $clog2((MAX_MASK - 1) / 2 + 1);
	localparam int EW   = $clog2(MAX_MASK + 1);
	localparam int CW   = $clog2(MAX_MASK * MAX_MASK * MAX_MASK + 1);

	logic            busy, q_valid, q_pop;
	vox_t            q_item;
	logic [DW-1:0]   sx, sy, sz;
	logic [RW-1:0]   r;
	logic [EW-1:0]   edge_len;
	logic [PLW-1:0]  plane;
	logic [POSW-1:0] total, lag;
	logic [CW-1:0]   cnt;

	bmf3_cfg #(.MAX_DIM(MAX_DIM), .MAX_MASK(MAX_MASK)) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.busy      (busy),
		.sx        (sx),
		.sy        (sy),
		.sz        (sz),
		.r         (r),
		.edge_len  (edge_len),
		.plane     (plane),
		.total     (total),
		.lag       (lag),
		.cnt       (cnt)
	);

	bmf3_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.hold      (busy),
		.vox_valid (vox_valid),
		.vox_stall (vox_stall),
		.vox       (vox),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.q_pop     (q_pop)
	);

	bmf3_back #(.MAX_DIM(MAX_DIM), .MAX_MASK(MAX_MASK)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.restart   (cfg_we),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.q_pop     (q_pop),
		.sx        (sx),
		.sy        (sy),
		.sz        (sz),
		.r         (r),
		.edge_len  (edge_len),
		.plane     (plane),
		.total     (total),
		.lag       (lag),
		.cnt       (cnt),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

endmodule

// ===== src/bmf3_cfg.sv =====
module bmf3_cfg #(
	parameter int MAX_DIM  = bmf3_pkg::MAX_DIM_DEF,
	parameter int MAX_MASK = bmf3_pkg::MAX_MASK_DEF,
	localparam int DW   = $clog2(MAX_DIM + 1),
	localparam int PLW  = $clog2(MAX_DIM * MAX_DIM + 1),
	localparam int POSW = $clog2(MAX_DIM * MAX_DIM * MAX_DIM + 1),
	localparam int RMAX = (MAX_MASK - 1) / 2,
	localparam int RW   = $clog2(RMAX + 1),
	localparam int EW   = $clog2(MAX_MASK + 1),
	localparam int CW   = $clog2(MAX_MASK * MAX_MASK * MAX_MASK + 1)
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [bmf3_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bmf3_pkg::CFG_W-1:0]      cfg_wdata,
	output logic                            busy,
	output logic [DW-1:0]                   sx,
	output logic [DW-1:0]                   sy,
	output logic [DW-1:0]                   sz,
	output logic [RW-1:0]                   r,
	output logic [EW-1:0]                   edge_len,
	output logic [PLW-1:0]                  plane,
	output logic [POSW-1:0]                 total,
	output logic [POSW-1:0]                 lag,
	output logic [CW-1:0]                   cnt
);
	import bmf3_pkg::*;

	logic [CFG_W-1:0]  size_x_q, size_y_q, size_z_q;
	logic [MASK_W-1:0] mask_q;
	logic [1:0]        busy_q;
	logic [EW-1:0]     m_c;

	logic [DW-1:0]     sx_s1, sy_s1, sz_s1;
	logic [RW-1:0]     r_s1;
	logic [EW-1:0]     edge_s1;
	logic [PLW-1:0]    plane_s1;
	logic [POSW-1:0]   rz_s1;
	logic [2*EW-1:0]   edge2_s1;

	function automatic logic [DW-1:0] clamp_dim(input logic [CFG_W-1:0] v);
		logic [DW-1:0] res_v;
		if (v == '0)
			res_v = DW'(1);
		else if (32'(v) > MAX_DIM)
			res_v = DW'(MAX_DIM);
		else
			res_v = DW'(v);
		return res_v;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_x_q <= SIZE_RST;
			size_y_q <= SIZE_RST;
			size_z_q <= SIZE_RST;
			mask_q   <= MASK_RST;
			busy_q   <= 2'd3;
		end else begin
			if (cfg_we) begin
				busy_q <= 2'd3;
				unique case (cfg_index)
					REG_SIZE_X: size_x_q <= cfg_wdata;
					REG_SIZE_Y: size_y_q <= cfg_wdata;
					REG_SIZE_Z: size_z_q <= cfg_wdata;
					REG_MASK:   mask_q   <= cfg_wdata[MASK_W-1:0];
				endcase
			end else if (busy_q != 2'd0) begin
				busy_q <= busy_q - 2'd1;
			end
		end
	end

	assign busy = (busy_q != 2'd0);

	always_comb begin
		if (32'(mask_q) > MAX_MASK)
			m_c = EW'(MAX_MASK);
		else
			m_c = EW'(mask_q);
		if (!m_c[0])
			m_c = (m_c == '0) ? EW'(1) : m_c - EW'(1);
	end

	always_ff @(posedge clk) begin
		sx_s1    <= clamp_dim(size_x_q);
		sy_s1    <= clamp_dim(size_y_q);
		sz_s1    <= clamp_dim(size_z_q);
		r_s1     <= RW'(m_c >> 1);
		edge_s1  <= m_c;
		plane_s1 <= PLW'(clamp_dim(size_y_q)) * PLW'(clamp_dim(size_z_q));
		rz_s1    <= POSW'(m_c >> 1) * POSW'(clamp_dim(size_z_q));
		edge2_s1 <= (2*EW)'(m_c) * (2*EW)'(m_c);

		sx       <= sx_s1;
		sy       <= sy_s1;
		sz       <= sz_s1;
		r        <= r_s1;
		edge_len <= edge_s1;
		plane    <= plane_s1;
		total    <= POSW'(sx_s1) * POSW'(plane_s1);
		lag      <= POSW'(r_s1) * POSW'(plane_s1) + rz_s1 + POSW'(r_s1);
		cnt      <= CW'(CW'(edge2_s1) * CW'(edge_s1));
	end

endmodule

// ===== src/bmf3_front.sv =====
module bmf3_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           hold,
	input  logic           vox_valid,
	output logic           vox_stall,
	input  bmf3_pkg::vox_t vox,
	output logic           q_valid,
	output bmf3_pkg::vox_t q_item,
	input  logic           q_pop
);
	import bmf3_pkg::*;

	vox_t             fifo_q [FQ_DEPTH];
	logic [FQ_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [FQ_AW:0]   cnt_q;
	logic             push;
	vox_t             item_c;

	assign vox_stall = hold || (cnt_q == (FQ_AW+1)'(FQ_DEPTH));
	assign push      = vox_valid && !vox_stall;
	assign q_valid   = (cnt_q != '0);
	assign q_item    = fifo_q[rd_ptr_q];

	// filler transactions carry no voxel
	always_comb begin
		item_c = vox;
		if (vox.flush)
			item_c.voxel_in = '0;
	end

	always_ff @(posedge clk) begin
		if (push)
			fifo_q[wr_ptr_q] <= item_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + FQ_AW'(1);
			if (q_pop)
				rd_ptr_q <= rd_ptr_q + FQ_AW'(1);
			if (push && !q_pop)
				cnt_q <= cnt_q + (FQ_AW+1)'(1);
			else if (!push && q_pop)
				cnt_q <= cnt_q - (FQ_AW+1)'(1);
		end
	end

endmodule

// ===== src/bmf3_back.sv =====
module bmf3_back #(
	parameter int MAX_DIM  = bmf3_pkg::MAX_DIM_DEF,
	parameter int MAX_MASK = bmf3_pkg::MAX_MASK_DEF,
	localparam int DW     = $clog2(MAX_DIM + 1),
	localparam int PLW    = $clog2(MAX_DIM * MAX_DIM + 1),
	localparam int POSW   = $clog2(MAX_DIM * MAX_DIM * MAX_DIM + 1),
	localparam int RMAX   = (MAX_MASK - 1) / 2,
	localparam int RW     = $clog2(RMAX + 1),
	localparam int EW     = $clog2(MAX_MASK + 1),
	localparam int CW     = $clog2(MAX_MASK * MAX_MASK * MAX_MASK + 1),
	localparam int LAGMAX = RMAX * (MAX_DIM * MAX_DIM + MAX_DIM + 1),
	localparam int AW     = $clog2(2 * LAGMAX + 2)
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            restart,
	input  logic            q_valid,
	input  bmf3_pkg::vox_t  q_item,
	output logic            q_pop,
	input  logic [DW-1:0]   sx,
	input  logic [DW-1:0]   sy,
	input  logic [DW-1:0]   sz,
	input  logic [RW-1:0]   r,
	input  logic [EW-1:0]   edge_len,
	input  logic [PLW-1:0]  plane,
	input  logic [POSW-1:0] total,
	input  logic [POSW-1:0] lag,
	input  logic [CW-1:0]   cnt,
	output logic            res_valid,
	input  logic            res_stall,
	output bmf3_pkg::res_t  res
);
	import bmf3_pkg::*;

	localparam int SUMW = VOXEL_BITS + CW;
	localparam int DIVN = SUMW - 1;
	localparam int DCW  = $clog2(DIVN + 1);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_SUM   = 3'd1;
	localparam logic [2:0] ST_DRAIN = 3'd2;
	localparam logic [2:0] ST_PREP  = 3'd3;
	localparam logic [2:0] ST_DIV   = 3'd4;
	localparam logic [2:0] ST_RD0   = 3'd5;
	localparam logic [2:0] ST_RD1   = 3'd6;

	logic [VOXEL_BITS-1:0] mem [2**AW];

	logic [2:0]            state_q;
	logic [POSW-1:0]       in_pos_q, out_pos_q, in_pos_nx;
	logic [DW-1:0]         x_q, y_q, z_q;
	logic [EW-1:0]         a_q, b_q, c_q;
	logic [DCW-1:0]        div_cnt_q;
	logic                  res_valid_q, rd_vld_s1;
	logic                  buf_valid_q;
	logic [POSW-1:0]       addr_q, row_q, pln_q, start_c;
	logic [VOXEL_BITS-1:0] rdata_s1;
	logic signed [SUMW-1:0] acc_q;
	logic [DIVN-1:0]       num_q;
	logic [CW-1:0]         rem_q;
	logic [CW:0]           rem_sh;
	logic                  ge;
	res_t                  res_q, buf_q;

	logic                  wr_en, int_c, emit, fin;
	logic [POSW:0]         need_c;
	logic                  c_last, b_last, a_last;
	logic [VOXEL_BITS-1:0] fin_val;
	logic                  vol_end;
	logic                  take, load_res, load_buf, move_buf;

	assign q_pop     = q_valid && (state_q == ST_IDLE) && !buf_valid_q;
	assign wr_en     = q_pop && !q_item.flush && (in_pos_q < total);
	assign in_pos_nx = in_pos_q + POSW'(wr_en);

	assign int_c = ((DW+1)'(x_q) >= (DW+1)'(r)) && (((DW+1)'(x_q) + (DW+1)'(r)) < (DW+1)'(sx))
		&& ((DW+1)'(y_q) >= (DW+1)'(r)) && (((DW+1)'(y_q) + (DW+1)'(r)) < (DW+1)'(sy))
		&& ((DW+1)'(z_q) >= (DW+1)'(r)) && (((DW+1)'(z_q) + (DW+1)'(r)) < (DW+1)'(sz));

	assign need_c  = int_c ? (POSW+1)'(out_pos_q) + (POSW+1)'(lag) : (POSW+1)'(out_pos_q);
	assign emit    = q_pop && (out_pos_q < total) && (need_c < (POSW+1)'(in_pos_nx));
	assign start_c = int_c ? out_pos_q - lag : out_pos_q;

	assign c_last = (c_q == edge_len - EW'(1));
	assign b_last = (b_q == edge_len - EW'(1));
	assign a_last = (a_q == edge_len - EW'(1));

	assign rem_sh = {rem_q, num_q[DIVN-1]};
	assign ge     = (rem_sh >= (CW+1)'(cnt));

	always_comb begin
		fin     = 1'b0;
		fin_val = '0;
		unique case (state_q)
			ST_RD1: begin
				fin     = 1'b1;
				fin_val = rdata_s1;
			end
			ST_PREP: begin
				fin = (acc_q <= 0);
			end
			ST_DIV: begin
				fin     = (div_cnt_q == DCW'(DIVN));
				fin_val = num_q[VOXEL_BITS-1:0];
			end
			default: begin
				fin = 1'b0;
			end
		endcase
	end

	assign vol_end = (out_pos_q + POSW'(1) == total);

	// two-entry result stage: one waiting result does not hold off the back end; two do
	assign take     = res_valid_q && !res_stall;
	assign load_res = fin && (!res_valid_q || take);
	assign load_buf = fin && res_valid_q && !take;
	assign move_buf = take && buf_valid_q;

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[in_pos_q[AW-1:0]] <= q_item.voxel_in;
		rdata_s1 <= mem[addr_q[AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			addr_q <= start_c;
			row_q  <= start_c;
			pln_q  <= start_c;
			acc_q  <= '0;
		end else begin
			if (state_q == ST_SUM) begin
				if (!c_last) begin
					addr_q <= addr_q + POSW'(1);
				end else if (!b_last) begin
					addr_q <= row_q + POSW'(sz);
					row_q  <= row_q + POSW'(sz);
				end else begin
					addr_q <= pln_q + POSW'(plane);
					row_q  <= pln_q + POSW'(plane);
					pln_q  <= pln_q + POSW'(plane);
				end
			end
			if (rd_vld_s1)
				acc_q <= acc_q + SUMW'(signed'(rdata_s1));
		end
		if (state_q == ST_PREP) begin
			num_q <= acc_q[DIVN-1:0];
			rem_q <= '0;
		end else if (state_q == ST_DIV && !fin) begin
			rem_q <= ge ? CW'(rem_sh - (CW+1)'(cnt)) : rem_sh[CW-1:0];
			num_q <= {num_q[DIVN-2:0], ge};
		end
		if (load_res) begin
			res_q.voxel_out <= fin_val;
			res_q.last      <= vol_end;
		end else if (move_buf) begin
			res_q <= buf_q;
		end
		if (load_buf) begin
			buf_q.voxel_out <= fin_val;
			buf_q.last      <= vol_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			in_pos_q    <= '0;
			out_pos_q   <= '0;
			x_q         <= '0;
			y_q         <= '0;
			z_q         <= '0;
			a_q         <= '0;
			b_q         <= '0;
			c_q         <= '0;
			div_cnt_q   <= '0;
			res_valid_q <= 1'b0;
			buf_valid_q <= 1'b0;
			rd_vld_s1   <= 1'b0;
		end else begin
			rd_vld_s1 <= (state_q == ST_SUM);

			if (load_res)
				res_valid_q <= 1'b1;
			else if (take && !buf_valid_q)
				res_valid_q <= 1'b0;

			if (load_buf)
				buf_valid_q <= 1'b1;
			else if (move_buf)
				buf_valid_q <= 1'b0;

			unique case (state_q)
				ST_IDLE: begin
					if (emit) begin
						state_q <= int_c ? ST_SUM : ST_RD0;
						a_q     <= '0;
						b_q     <= '0;
						c_q     <= '0;
					end
				end
				ST_SUM: begin
					if (!c_last) begin
						c_q <= c_q + EW'(1);
					end else if (!b_last) begin
						c_q <= '0;
						b_q <= b_q + EW'(1);
					end else begin
						c_q <= '0;
						b_q <= '0;
						a_q <= a_q + EW'(1);
						if (a_last)
							state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_PREP;
				end
				ST_PREP: begin
					div_cnt_q <= '0;
					state_q   <= fin ? ST_IDLE : ST_DIV;
				end
				ST_DIV: begin
					if (fin)
						state_q <= ST_IDLE;
					else
						div_cnt_q <= div_cnt_q + DCW'(1);
				end
				ST_RD0: begin
					state_q <= ST_RD1;
				end
				ST_RD1: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			priority if (restart) begin
				in_pos_q  <= '0;
				out_pos_q <= '0;
				x_q       <= '0;
				y_q       <= '0;
				z_q       <= '0;
			end else if (fin && vol_end) begin
				in_pos_q  <= '0;
				out_pos_q <= '0;
				x_q       <= '0;
				y_q       <= '0;
				z_q       <= '0;
			end else begin
				in_pos_q <= in_pos_nx;
				if (fin) begin
					out_pos_q <= out_pos_q + POSW'(1);
					if (z_q + DW'(1) != sz) begin
						z_q <= z_q + DW'(1);
					end else begin
						z_q <= '0;
						if (y_q + DW'(1) != sy) begin
							y_q <= y_q + DW'(1);
						end else begin
							y_q <= '0;
							x_q <= x_q + DW'(1);
						end
					end
				end
			end
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

`ifndef SYNTHESIS
	a_out_behind_in: assert property (@(posedge clk) disable iff (!arst_n)
		out_pos_q <= in_pos_q)
		else $error("output position ahead of input position");

	a_drain_has_data: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DRAIN) |-> rd_vld_s1)
		else $error("window drain without pending read");

	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> ($past(state_q) != ST_IDLE))
		else $error("result raised from idle");

	a_sum_flow: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SUM) |=> (state_q == ST_SUM || state_q == ST_DRAIN))
		else $error("window sum interrupted");
`endif

endmodule
